// ===== hw/rtl/wgm_pkg.sv =====
// Shared types and constants for the wildcard glob matcher.
// Used by wgm_cell, wildcard_glob_matcher and wgm_chk; no other dependencies.
package wgm_pkg;

    // Pattern store depth, one cell per stored pattern byte
    localparam int unsigned MAX_PATTERN = 32;

    // Wildcard bytes
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;

    // Input beat commands
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } t_cmd;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic       clear;    // drop pattern, re-arm
        logic       append;   // store byte in the first free cell
        logic       text;     // advance active set by one text byte
        logic       rearm;    // end of text: back to position zero
        logic [7:0] ch;       // pattern or text byte
    } t_cell_ctl;

endpackage

// ===== hw/rtl/wgm_cell.sv =====
// One pattern position of the matcher: stored byte, occupancy and active bit.
// Depends on wgm_pkg for the control struct and wildcard constants.
module wgm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wgm_pkg::t_cell_ctl i_ctl,
    input  logic               i_arm_val,    // active value after clear or re-arm
    input  logic               i_prev_valid, // left neighbor holds a byte
    input  logic               i_close_in,   // star closure from the left
    input  logic               i_match_in,   // left neighbor consumed the byte
    output logic               o_valid,
    output logic               o_close_out,
    output logic               o_match_out,
    output logic               o_end_hit
);

    logic       r_valid;
    logic       r_active;
    logic [7:0] r_char;
    logic       n_active;
    logic       w_close;
    logic       w_hit;
    logic       w_star;
    logic       w_take;

    // Close the active bit over a run of stars to the left
    assign w_close = r_active | i_close_in;
    assign w_hit   = w_close & r_valid;
    assign w_star  = (r_char == wgm_pkg::CH_STAR);
    assign w_take  = i_ctl.append & i_prev_valid & ~r_valid;

    assign o_valid     = r_valid;
    assign o_close_out = w_hit & w_star;
    assign o_match_out = w_hit & ~w_star &
                         ((r_char == wgm_pkg::CH_QUEST) | (r_char == i_ctl.ch));
    // This cell sits just past the last stored byte
    assign o_end_hit   = w_close & ~r_valid & i_prev_valid;

    // Pick the next active bit
    always_comb begin
        n_active = r_active;
        if (i_ctl.clear || i_ctl.rearm) begin
            n_active = i_arm_val;
        end else if (i_ctl.text) begin
            n_active = o_close_out | i_match_in;
        end
    end

    // Hold occupancy and active state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_active <= i_arm_val;
        end else begin
            r_active <= n_active;
            if (i_ctl.clear) begin
                r_valid <= 1'b0;
            end else if (w_take) begin
                r_valid <= 1'b1;
            end
        end
    end

    // Capture the pattern byte
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_char <= i_ctl.ch;
        end
    end

endmodule

// ===== hw/rtl/wildcard_glob_matcher.sv =====
// Top level of the wildcard glob matcher: a row of wgm_cell and the result register.
// Depends on wgm_pkg and wgm_cell.
//
//   channel | direction | handshake               | payload
//   in      | to block  | i_in_valid / o_in_stall | i_command, i_char_byte
//   out     | from block| o_out_valid / i_out_stall| o_matched, o_pattern_overflow
//
// A new beat can be taken in every cycle in which input is not stalled.
// The path per cycle is the star-closure ripple across the row of MAX_PATTERN cells.
// An end-of-text beat gives its result in the next cycle in the output register.
// Input is stalled only while a result sits in the output register and out is stalled.
// Reset (synchronous, active low) empties the pattern and arms position zero.
module wildcard_glob_matcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_char_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_matched,
    output logic       o_pattern_overflow
);

    localparam int unsigned N = wgm_pkg::MAX_PATTERN;

    wgm_pkg::t_cell_ctl w_ctl;
    logic               w_accept;
    wgm_pkg::t_cmd      w_cmd;
    logic [N-1:0]       w_valid;
    logic [N-1:0]       w_close;
    logic [N-1:0]       w_match;
    logic [N-1:0]       w_end_hit;
    logic               w_tail_close;
    logic               w_verdict;
    logic               r_tail_active;
    logic               r_ovf;
    logic               r_out_valid;
    logic               r_matched;
    logic               r_out_ovf;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_cmd      = wgm_pkg::t_cmd'(i_command);

    // Decode the beat into cell controls
    always_comb begin
        w_ctl        = '0;
        w_ctl.ch     = i_char_byte;
        if (w_accept) begin
            case (w_cmd)
                wgm_pkg::CMD_CLEAR:  w_ctl.clear  = 1'b1;
                wgm_pkg::CMD_APPEND: w_ctl.append = 1'b1;
                wgm_pkg::CMD_TEXT:   w_ctl.text   = 1'b1;
                wgm_pkg::CMD_END:    w_ctl.rearm  = 1'b1;
                default:             w_ctl.rearm  = 1'b0;
            endcase
        end
    end

    // Row of pattern cells, each chained to its left neighbor
    for (genvar g = 0; g < N; g++) begin : g_cell
        wgm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_arm_val    ((g == 0) ? 1'b1 : 1'b0),
            .i_prev_valid ((g == 0) ? 1'b1 : w_valid[(g == 0) ? 0 : g-1]),
            .i_close_in   ((g == 0) ? 1'b0 : w_close[(g == 0) ? 0 : g-1]),
            .i_match_in   ((g == 0) ? 1'b0 : w_match[(g == 0) ? 0 : g-1]),
            .o_valid      (w_valid[g]),
            .o_close_out  (w_close[g]),
            .o_match_out  (w_match[g]),
            .o_end_hit    (w_end_hit[g])
        );
    end

    // Position past a full store
    assign w_tail_close = r_tail_active | w_close[N-1];
    assign w_verdict    = (|w_end_hit) | (w_tail_close & w_valid[N-1]);

    // Hold the tail position and the overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_active <= 1'b0;
            r_ovf         <= 1'b0;
        end else begin
            if (w_ctl.clear || w_ctl.rearm) begin
                r_tail_active <= 1'b0;
            end else if (w_ctl.text) begin
                r_tail_active <= w_match[N-1];
            end
            if (w_ctl.clear) begin
                r_ovf <= 1'b0;
            end else if (w_ctl.append && w_valid[N-1]) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Load the result beat, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.rearm) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.rearm) begin
            r_matched <= w_verdict;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_matched          = r_matched;
    assign o_pattern_overflow = r_out_ovf;

endmodule

// ===== hw/rtl/wgm_chk.sv =====
// Port-level assertions for the wildcard glob matcher, bound to the top level.
// Depends on wgm_pkg for the command codes.
module wgm_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_command,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_matched,
    input logic       o_pattern_overflow
);

    logic w_in_acc;
    logic w_end_acc;
    logic w_clr_acc;

    assign w_in_acc  = i_in_valid & ~o_in_stall;
    assign w_end_acc = w_in_acc & (i_command == wgm_pkg::CMD_END);
    assign w_clr_acc = w_in_acc & (i_command == wgm_pkg::CMD_CLEAR);

    // A stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_matched)
                                       && $stable(o_pattern_overflow))
        else $error("result beat changed while stalled");

    // End of text yields a result beat in the next cycle
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_acc |=> o_out_valid)
        else $error("end of text gave no result");

    // No result beat appears without an end of text
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_end_acc && !(o_out_valid && i_out_stall) |=> !o_out_valid)
        else $error("result beat without end of text");

    // Input is stalled only behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with free output");

    // Empty pattern against empty text matches, with no overflow
    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_acc ##1 w_end_acc |=> o_matched && !o_pattern_overflow)
        else $error("empty pattern did not match empty text");

endmodule

bind wildcard_glob_matcher wgm_chk u_wgm_chk (.*);
